// ===== design/owd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owd_pkg;

   localparam int MAX_WINDOW    = 64;
   localparam int SAMPLE_BITS   = 16;
   localparam int PTR_BITS      = $clog2(MAX_WINDOW);
   localparam int WIN_BITS      = PTR_BITS + 1;
   localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS + 1;
   localparam int FRAC_BITS     = 8;
   localparam int MEAN_BITS     = 24;
   localparam int CNT_BITS      = 16;
   localparam int DIV_BITS      = SUM_BITS - 1 + FRAC_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LEN  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERLAP_LEN = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_OUTPUTS = CSR_IDX_BITS'(2);

   typedef struct packed {
      logic load_in;
      logic update;
      logic div_step;
      logic load_out;
   } owd_cmd_type;

   typedef struct packed {
      logic emit;
      logic last_in;
      logic div_done;
      logic result_pending;
      logic out_busy;
   } owd_status_type;

   function automatic logic signed [SUM_BITS-1:0] owd_sext(
      input logic signed [SAMPLE_BITS-1:0] s
   );
      return {{(SUM_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

endpackage

`default_nettype wire

// ===== design/owd_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface owd_req_if import owd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface owd_rsp_if import owd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [MEAN_BITS-1:0] mean;
   logic                        has_mean;
   logic                        is_last;
   logic [CNT_BITS-1:0]         windows_out;

   modport source (output valid, output mean, output has_mean, output is_last,
                   output windows_out, input ready);
   modport sink (input valid, input mean, input has_mean, input is_last,
                 input windows_out, output ready);
endinterface

interface owd_csr_if import owd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/owd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owd_ctrl import owd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire owd_status_type status,
   output owd_cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.emit) begin
               state_in = ST_DIVIDE;
            end else if (status.last_in) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold here while the previous beat still sits in the output register
            if (!status.result_pending) begin
               state_in = ST_IDLE;
            end else if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_goes_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE && status.emit |=> state_ff == ST_DIVIDE)
      else $error("window mean not sent to divider");

   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && !status.div_done |=> state_ff == ST_DIVIDE)
      else $error("divider left before last step");

endmodule

`default_nettype wire

// ===== design/owd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owd_datapath import owd_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire owd_cmd_type                   cmd,
   output owd_status_type                     status,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_last,
   input  wire logic                          csr_valid,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [MEAN_BITS-1:0]        rsp_mean,
   output logic                               rsp_has_mean,
   output logic                               rsp_is_last,
   output logic [CNT_BITS-1:0]                rsp_windows_out
);

   // configuration
   logic [WIN_BITS-1:0] window_len_ff;
   logic [PTR_BITS-1:0] overlap_len_ff;
   logic [CNT_BITS-1:0] max_outputs_ff;
   logic                restart;
   logic [WIN_BITS-1:0] eff_w;
   logic [WIN_BITS-1:0] stride;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= WIN_BITS'(1);
         overlap_len_ff <= '0;
         max_outputs_ff <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LEN:  window_len_ff  <= csr_data[WIN_BITS-1:0];
            CSR_OVERLAP_LEN: overlap_len_ff <= csr_data[PTR_BITS-1:0];
            CSR_MAX_OUTPUTS: max_outputs_ff <= csr_data[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_valid &&
                    (csr_index == CSR_WINDOW_LEN || csr_index == CSR_OVERLAP_LEN);

   always_comb begin
      if (window_len_ff == '0) begin
         eff_w = WIN_BITS'(1);
      end else if (window_len_ff > WIN_BITS'(MAX_WINDOW)) begin
         eff_w = WIN_BITS'(MAX_WINDOW);
      end else begin
         eff_w = window_len_ff;
      end
      if (WIN_BITS'(overlap_len_ff) >= eff_w) begin
         stride = WIN_BITS'(1);
      end else begin
         stride = eff_w - WIN_BITS'(overlap_len_ff);
      end
   end

   // input beat and sample history
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          last_ff;
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_rd_ff;
   logic [PTR_BITS-1:0]           wp_ff;
   logic [PTR_BITS-1:0]           oldest;

   // the oldest sample of a full window, the one that drops out of it
   assign oldest = wp_ff - eff_w[PTR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff  <= req_sample;
         last_ff    <= req_last;
         ring_rd_ff <= ring_mem[oldest];
      end
      if (cmd.update) begin
         ring_mem[wp_ff] <= sample_ff;
      end
   end

   // window state
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [WIN_BITS-1:0]        fill_ff, fill_in, fill_inc;
   logic [PTR_BITS-1:0]        phase_ff, phase_in;
   logic [WIN_BITS-1:0]        phase_inc;
   logic [CNT_BITS-1:0]        emitted_ff, emitted_in;
   logic [PTR_BITS-1:0]        wp_in;
   logic                       full;
   logic                       emit;

   assign full      = (fill_ff >= eff_w);
   assign emit      = full && (phase_ff == '0) && (emitted_ff < max_outputs_ff);
   assign fill_inc  = fill_ff + 1'b1;
   assign phase_inc = WIN_BITS'(phase_ff) + 1'b1;

   always_comb begin
      wp_in      = wp_ff;
      sum_in     = sum_ff;
      fill_in    = fill_ff;
      phase_in   = phase_ff;
      emitted_in = emitted_ff;
      if (cmd.update) begin
         wp_in = wp_ff + 1'b1;
         if (full) begin
            phase_in = (phase_inc >= stride) ? '0 : phase_inc[PTR_BITS-1:0];
            sum_in   = sum_ff - owd_sext(ring_rd_ff) + owd_sext(sample_ff);
         end else begin
            sum_in  = sum_ff + owd_sext(sample_ff);
            fill_in = fill_inc;
            if (fill_inc >= eff_w) begin
               phase_in = '0;
            end
         end
         if (emit) begin
            emitted_in = emitted_ff + 1'b1;
         end
         if (last_ff) begin
            wp_in      = '0;
            sum_in     = '0;
            fill_in    = '0;
            phase_in   = '0;
            emitted_in = '0;
         end
      end
      if (restart) begin
         wp_in      = '0;
         sum_in     = '0;
         fill_in    = '0;
         phase_in   = '0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         sum_ff     <= '0;
         fill_ff    <= '0;
         phase_ff   <= '0;
         emitted_ff <= '0;
      end else begin
         wp_ff      <= wp_in;
         sum_ff     <= sum_in;
         fill_ff    <= fill_in;
         phase_ff   <= phase_in;
         emitted_ff <= emitted_in;
      end
   end

   // pending result fields, captured before the trace restarts
   logic                pend_has_ff;
   logic                pend_last_ff;
   logic [CNT_BITS-1:0] pend_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_has_ff  <= 1'b0;
         pend_last_ff <= 1'b0;
      end else if (cmd.update) begin
         pend_has_ff  <= emit;
         pend_last_ff <= last_ff;
      end else if (cmd.load_out) begin
         pend_has_ff  <= 1'b0;
         pend_last_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         pend_win_ff <= emitted_ff + CNT_BITS'(emit);
      end
   end

   // restoring divider on magnitudes, one quotient bit per cycle
   logic [SUM_BITS-1:0]     sum_abs;
   logic [DIV_BITS-1:0]     div_dvd_ff;
   logic [WIN_BITS-1:0]     div_rem_ff;
   logic [WIN_BITS:0]       rem_shift;
   logic [WIN_BITS:0]       rem_diff;
   logic                    qbit;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic                    div_neg_ff;
   logic [MEAN_BITS-1:0]    quot;
   logic [MEAN_BITS-1:0]    mean_val;

   assign sum_abs   = sum_ff[SUM_BITS-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign rem_shift = {div_rem_ff, div_dvd_ff[DIV_BITS-1]};
   assign qbit      = (rem_shift >= {1'b0, eff_w});
   assign rem_diff  = rem_shift - {1'b0, eff_w};

   always_ff @(posedge clock) begin
      if (cmd.update && emit) begin
         div_neg_ff <= sum_ff[SUM_BITS-1];
         div_dvd_ff <= {sum_abs[SUM_BITS-2:0], {FRAC_BITS{1'b0}}};
         div_rem_ff <= '0;
         div_cnt_ff <= DIV_CNT_BITS'(DIV_BITS - 1);
      end else if (cmd.div_step) begin
         div_dvd_ff <= {div_dvd_ff[DIV_BITS-2:0], qbit};
         div_rem_ff <= qbit ? rem_diff[WIN_BITS-1:0] : rem_shift[WIN_BITS-1:0];
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   assign quot     = div_dvd_ff[MEAN_BITS-1:0];
   assign mean_val = div_neg_ff ? (~quot + 1'b1) : quot;

   // output register
   logic                        out_valid_ff;
   logic signed [MEAN_BITS-1:0] out_mean_ff;
   logic                        out_has_ff;
   logic                        out_last_ff;
   logic [CNT_BITS-1:0]         out_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_mean_ff <= pend_has_ff ? mean_val : '0;
         out_has_ff  <= pend_has_ff;
         out_last_ff <= pend_last_ff;
         out_win_ff  <= pend_win_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_mean        = out_mean_ff;
   assign rsp_has_mean    = out_has_ff;
   assign rsp_is_last     = out_last_ff;
   assign rsp_windows_out = out_win_ff;

   assign status.emit           = emit;
   assign status.last_in        = last_ff;
   assign status.div_done       = (div_cnt_ff == '0);
   assign status.result_pending = pend_has_ff || pend_last_ff;
   assign status.out_busy       = out_valid_ff && !rsp_ready;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_w)
      else $error("fill count beyond window length");

   a_phase_bounded: assert property (@(posedge clock) disable iff (reset)
      WIN_BITS'(phase_ff) < stride)
      else $error("stride phase out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(out_valid_ff && !rsp_ready))
      else $error("output register overwritten while beat not taken");

endmodule

`default_nettype wire

// ===== design/overlapped_window_decimator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Boxcar decimator with overlap: each req beat carries one signed trace sample. Once a
// window of window_len samples (0 read as 1, above 64 as 64) has filled, every stride-th
// sample (stride = window_len - overlap_len, at least one) emits the mean of the previous
// window_len samples on rsp, as a signed fixed-point value with 8 fraction bits truncated
// toward zero, up to max_outputs means per trace. The sample flagged last always gives a
// beat carrying the window count (has_mean 0 and mean 0 if no window closed on it) and
// restarts the trace; writing window_len or overlap_len restarts it too. One sample is
// handled at a time, in the update state, then for a mean the bit-serial divider forming
// sum*256/window_len, then for a beat the result state. A finished beat waits in the
// output register while the next sample is taken; only a second result waits for it to
// drain. csr writes are always accepted; the user must keep them to idle periods.
module overlapped_window_decimator_core import owd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   owd_req_if.sink   req_if,
   owd_rsp_if.source rsp_if,
   owd_csr_if.sink   csr_if
);

   owd_cmd_type    cmd;
   owd_status_type status;
   logic           req_ready;

   owd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   owd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_if.sample),
      .req_last        (req_if.last),
      .csr_valid       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_mean        (rsp_if.mean),
      .rsp_has_mean    (rsp_if.has_mean),
      .rsp_is_last     (rsp_if.is_last),
      .rsp_windows_out (rsp_if.windows_out)
   );

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

endmodule

`default_nettype wire

// ===== verif/owd_window_checker.sv =====
`timescale 1ns / 1ps

module owd_window_checker import owd_pkg::*; (
   input  logic clock,
   input  logic reset,
   owd_req_if   req_if,
   owd_rsp_if   rsp_if,
   owd_csr_if   csr_if,
   output int   fail_count,
   output int   results_pending,
   output int   results_seen,
   output int   means_seen
);

   typedef struct packed {
      logic signed [MEAN_BITS-1:0] mean;
      logic                        has_mean;
      logic                        is_last;
      logic [CNT_BITS-1:0]         windows_out;
   } window_result_type;

   window_result_type window_results_due[$];

   logic [WIN_BITS-1:0]           win_len;
   logic [PTR_BITS-1:0]           ovl_len;
   logic [CNT_BITS-1:0]           max_means;
   logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
   logic [PTR_BITS-1:0]           wr_ptr;
   longint                        window_sum;
   int                            fill;
   int                            stride_pos;
   int                            emitted;
   int                            errors;
   int                            beats;
   int                            means;

   task automatic restart_trace();
      wr_ptr     = '0;
      window_sum = 0;
      fill       = 0;
      stride_pos = 0;
      emitted    = 0;
   endtask

   // one accepted sample: slide the window and queue the beat it should cause
   task automatic advance_window(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
      int                  w;
      int                  stride;
      longint              quotient;
      logic [PTR_BITS-1:0] oldest;
      window_result_type   r;
      w      = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
      stride = (ovl_len >= w) ? 1 : w - ovl_len;
      r      = '0;
      if (fill >= w) begin
         if (stride_pos == 0 && emitted < max_means) begin
            quotient   = (window_sum * 256) / w;
            r.mean     = quotient[MEAN_BITS-1:0];
            r.has_mean = 1'b1;
            emitted++;
         end
         stride_pos = (stride_pos + 1 >= stride) ? 0 : stride_pos + 1;
         // a full 64-deep window wraps the pointer onto itself
         oldest     = wr_ptr - PTR_BITS'(w);
         window_sum = window_sum - history[oldest] + s;
      end else begin
         window_sum += s;
         fill++;
         if (fill >= w) stride_pos = 0;
      end
      history[wr_ptr] = s;
      wr_ptr++;
      if (r.has_mean || fin) begin
         r.is_last     = fin;
         r.windows_out = emitted[CNT_BITS-1:0];
         window_results_due.push_back(r);
      end
      if (fin) restart_trace();
   endtask

   always @(posedge clock) begin : watch
      window_result_type due;
      if (reset) begin
         win_len   = WIN_BITS'(1);
         ovl_len   = '0;
         max_means = '1;
         restart_trace();
         window_results_due.delete();
      end else begin
         // an output beat can never belong to a sample taken at the same edge
         if (rsp_if.valid && rsp_if.ready) begin
            beats++;
            if (window_results_due.size() == 0) begin
               $error("unexpected result beat: mean %0d, windows_out %0d",
                      rsp_if.mean, rsp_if.windows_out);
               errors++;
            end else begin
               due = window_results_due.pop_front();
               if (due.has_mean) means++;
               if (rsp_if.mean !== due.mean) begin
                  $error("mean: expected %0d, got %0d", due.mean, rsp_if.mean);
                  errors++;
               end
               if (rsp_if.has_mean !== due.has_mean) begin
                  $error("has_mean: expected %0d, got %0d", due.has_mean, rsp_if.has_mean);
                  errors++;
               end
               if (rsp_if.is_last !== due.is_last) begin
                  $error("is_last: expected %0d, got %0d", due.is_last, rsp_if.is_last);
                  errors++;
               end
               if (rsp_if.windows_out !== due.windows_out) begin
                  $error("windows_out: expected %0d, got %0d",
                         due.windows_out, rsp_if.windows_out);
                  errors++;
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_WINDOW_LEN: begin
                  win_len = csr_if.data[WIN_BITS-1:0];
                  restart_trace();
               end
               CSR_OVERLAP_LEN: begin
                  ovl_len = csr_if.data[PTR_BITS-1:0];
                  restart_trace();
               end
               CSR_MAX_OUTPUTS: max_means = csr_if.data[CNT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) advance_window(req_if.sample, req_if.last);
      end
      fail_count      <= errors;
      results_pending <= window_results_due.size();
      results_seen    <= beats;
      means_seen      <= means;
   end

endmodule

// ===== verif/tb_overlapped_window_decimator_core.sv =====
`timescale 1ns / 1ps

module tb_overlapped_window_decimator_core;
   import owd_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = CSR_IDX_BITS'(3);
   localparam int RANDOM_SAMPLES = 600;
   localparam int DRAIN_CYCLES   = 50;
   localparam int QUIET_LIMIT    = 2000;
   localparam int LONG_HOLD      = 300;

   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_MAX,
      SHAPE_MIN,
      SHAPE_ALTERNATE,
      SHAPE_TINY
   } sample_shape_type;

   logic clock;
   logic reset;

   owd_req_if req_if ();
   owd_rsp_if rsp_if ();
   owd_csr_if csr_if ();

   int fail_count;
   int results_pending;
   int results_seen;
   int means_seen;
   int samples_sent  = 0;
   int traces_sent   = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;
   int holds_wanted  = 0;
   int holds_done    = 0;
   int cur_window    = 1;
   bit burst         = 1'b0;

   overlapped_window_decimator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   owd_window_checker mean_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_seen    (results_seen),
      .means_seen      (means_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall before each beat, one long hold when asked
   initial begin : receiver
      int stall;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_done < holds_wanted) begin
            stall = LONG_HOLD;
            holds_done++;
         end else begin
            stall = burst ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      req_if.last   <= fin;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
   endtask

   task automatic send_trace(input int len, input sample_shape_type shape, input bit close);
      logic signed [SAMPLE_BITS-1:0] s;
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_MAX:       s = 16'sh7FFF;
            SHAPE_MIN:       s = 16'sh8000;
            SHAPE_ALTERNATE: s = i[0] ? 16'sh8000 : 16'sh7FFF;
            SHAPE_TINY:      s = 16'($urandom_range(0, 15) - 8);
            default:         s = SAMPLE_BITS'($urandom);
         endcase
         send_sample(s, close && i == len - 1);
      end
      if (close) traces_sent++;
   endtask

   // wait out every expected beat, then give the block some quiet cycles
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // unused upper data bits carry junk, the block keeps only the field width
   task automatic configure(input logic [6:0] win, input logic [5:0] ovl,
                            input logic [15:0] lim, input bit restart);
      logic [15:0] junk;
      junk = 16'($urandom);
      if (restart) begin
         write_reg(CSR_WINDOW_LEN, {junk[15:7], win});
         write_reg(CSR_OVERLAP_LEN, {junk[15:6], ovl});
         cur_window = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : int'(win);
      end
      write_reg(CSR_MAX_OUTPUTS, lim);
      write_reg(CSR_SPARE, ~junk);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      int               target;
      int               first_sample;
      int               len;
      int               phase_no;
      sample_shape_type shape;
      logic [6:0]       w_pick;
      logic [5:0]       ov_pick;
      logic [15:0]      mx_pick;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.last   = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.index  = '0;
      csr_if.data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: window of one, every later sample returns its predecessor
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shFFFF, 1'b0);
      send_sample(16'sh0001, 1'b1);
      traces_sent++;
      settle();

      configure(7'd4, 6'd2, 16'hFFFF, 1'b1);
      send_trace(9, SHAPE_MIN, 1'b1);
      send_trace(2, SHAPE_MAX, 1'b1);
      settle();

      // zero window, overlap past the window, two-mean cap
      configure(7'd0, 6'd5, 16'd2, 1'b1);
      send_trace(5, SHAPE_RANDOM, 1'b1);
      send_trace(1, SHAPE_ALTERNATE, 1'b1);
      settle();

      first_sample = samples_sent;
      phase_no     = 0;
      while (samples_sent - first_sample < RANDOM_SAMPLES) begin
         burst = (phase_no % 3 == 2);
         case (phase_no)
            0: configure(7'd64, 6'd63, 16'hFFFF, 1'b1);
            1: configure(7'd127, 6'd0, 16'hFFFF, 1'b1);
            2: configure(7'd1, 6'd0, 16'h0000, 1'b1);
            3: begin
               w_pick = 7'($urandom_range(2, 16));
               configure(w_pick, 6'($urandom_range(0, w_pick + 1)),
                         16'($urandom_range(1, 4)), 1'b1);
            end
            4: begin
               // every sample after a trace's first gives a mean, so a long hold backs up into req
               configure(7'd1, 6'd0, 16'hFFFF, 1'b1);
               holds_wanted++;
            end
            default: begin
               w_pick  = 7'($urandom_range(1, 12));
               ov_pick = $urandom_range(0, 1) ? 6'($urandom_range(0, w_pick - 1)) :
                                                6'($urandom_range(w_pick, 63));
               mx_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 6)) : 16'hFFFF;
               configure(w_pick, ov_pick, mx_pick, $urandom_range(0, 3) != 0);
            end
         endcase

         target = samples_sent + ((cur_window >= 32) ? 160 : $urandom_range(40, 90));
         while (samples_sent < target) begin
            case ($urandom_range(0, 5))
               0:       len = cur_window;
               1:       len = cur_window + 1;
               default: len = $urandom_range(1, 3 * cur_window + 4);
            endcase
            case ($urandom_range(0, 9))
               0:       shape = SHAPE_MAX;
               1:       shape = SHAPE_MIN;
               2:       shape = SHAPE_ALTERNATE;
               3:       shape = SHAPE_TINY;
               default: shape = SHAPE_RANDOM;
            endcase
            send_trace(len, shape, 1'b1);
         end
         // sometimes leave a trace open across the next register write
         if ($urandom_range(0, 3) == 0)
            send_trace($urandom_range(1, cur_window + 2), SHAPE_RANDOM, 1'b0);
         settle();
         phase_no++;
      end

      $display("drove %0d samples in %0d closed traces under %0d register settings",
               samples_sent, traces_sent, settings_used);
      $display("compared %0d result beats, %0d of them carrying a window mean",
               results_seen, means_seen);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
